// File: design/wpss_pkg.sv
// Package for the waypoint steering and speed controller: register codes, config type, constants.
`default_nettype none

package wpss_pkg;

	// Configuration register indexes, in port order.
	typedef enum logic [2:0] {
		REG_MAX_SPEED       = 3'd0,
		REG_MAX_STEER       = 3'd1,
		REG_ARRIVE_TOL      = 3'd2,
		REG_GAIN_NEAR       = 3'd3,
		REG_GAIN_FAR        = 3'd4,
		REG_GAIN_SWITCH     = 3'd5,
		REG_KI_PER_TICK     = 3'd6,
		REG_KD_PER_TICK     = 3'd7
	} reg_idx_t;

	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = 20;

	// Configuration register contents as seen by the datapath.
	typedef struct packed {
		logic [9:0]  max_speed;
		logic [14:0] max_steer_angle;
		logic [15:0] arrive_tolerance;
		logic [15:0] gain_near;
		logic [15:0] gain_far;
		logic [19:0] gain_switch_distance;
		logic [15:0] integral_gain_per_tick;
		logic [15:0] derivative_gain_per_tick;
	} cfg_t;

	// Reset values of the configuration registers.
	localparam logic [9:0]  RstMaxSpeed  = 10'd64;
	localparam logic [14:0] RstMaxSteer  = 15'd2145;
	localparam logic [15:0] RstArriveTol = 16'd16;
	localparam logic [15:0] RstGainNear  = 16'd819;
	localparam logic [15:0] RstGainFar   = 16'd1311;
	localparam logic [19:0] RstGainSw    = 20'd960;
	localparam logic [15:0] RstKi        = 16'd41;
	localparam logic [15:0] RstKd        = 16'd4096;

	// Heading error magnitude thresholds in Q4.12: 5 and 15 degrees.
	localparam logic [16:0] Deg5MaxQ12  = 17'd357;
	localparam logic [16:0] Deg15MinQ12 = 17'd1073;

	// Integral accumulator limits (40-bit signed).
	localparam logic signed [39:0] IntMax = {1'b0, {39{1'b1}}};
	localparam logic signed [39:0] IntMin = {1'b1, {39{1'b0}}};

	// Rounding offset for Q8.24 to Q4.12.
	localparam logic signed [41:0] RoundHalf = 42'sd2048;

endpackage

`default_nettype wire

// File: design/waypoint_pid_steer_speed_unit.sv
// Top level of the waypoint steering and speed controller.
// Throughput: one transaction per cycle while the output is not stalled; four registered
// stages (input, products, integral update, result) hand items on through per-stage ready,
// and a result reaches the output register after passing through each of them in turn.
// Reset: asynchronous active low; pipeline empty, integral and error history zero,
// arrived mark set, configuration registers at their reset values.
`default_nettype none

module waypoint_pid_steer_speed_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_write,
	input  wire logic [wpss_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire logic [wpss_pkg::CfgDataW-1:0] cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          new_target,
	input  wire logic signed [15:0]            hdg_err,
	input  wire logic [31:0]                   distance,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [15:0]                 steer_out,
	output logic [9:0]                         speed_cmd,
	output logic                               arrived
);
	import wpss_pkg::*;

	cfg_t cfg;

	wpss_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Stage valid bits and handshake chain.
	logic v_s1, v_s2, v_s3;
	logic r_out, r_s3, r_s2;
	logic adv_s1, adv_s2, adv_s3;

	assign r_out    = !out_valid || out_ready;
	assign r_s3     = !v_s3 || r_out;
	assign r_s2     = !v_s2 || r_s3;
	assign in_ready = !v_s1 || r_s2;
	assign adv_s1   = v_s1 && r_s2;
	assign adv_s2   = v_s2 && r_s3;
	assign adv_s3   = v_s3 && r_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (in_ready)
				v_s1 <= in_valid;
			if (r_s2)
				v_s2 <= v_s1;
			if (r_s3)
				v_s3 <= v_s2;
			if (r_out)
				out_valid <= v_s3;
		end
	end

	// Stage 1: input register.
	logic               nt_s1;
	logic signed [15:0] e_s1;
	logic [31:0]        dist_s1;

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			nt_s1   <= new_target;
			e_s1    <= hdg_err;
			dist_s1 <= distance;
		end
	end

	// Error history: the error of the last item that left stage 1.
	logic signed [15:0] prev_err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			prev_err_q <= '0;
		else if (adv_s1)
			prev_err_q <= e_s1;
	end

	// Stage 1 logic: thresholds, gain choice, the three products and the speed limit.
	logic signed [16:0] e_x;
	logic [16:0]        mag;
	logic               err_small, err_big;
	logic [15:0]        kp;
	logic signed [16:0] diff;
	logic signed [32:0] p_full;
	logic signed [33:0] d_full;
	logic signed [32:0] i_full;
	logic               at_tol;
	logic [9:0]         vlim;
	logic [9:0]         speed_raw;

	assign e_x       = {e_s1[15], e_s1};
	assign mag       = e_x[16] ? 17'(-e_x) : 17'(e_x);
	assign err_small = mag <= Deg5MaxQ12;
	assign err_big   = mag >= Deg15MinQ12;
	assign kp        = (dist_s1 < {12'd0, cfg.gain_switch_distance}) ? cfg.gain_near
	                                                                   : cfg.gain_far;
	assign diff      = e_x - {prev_err_q[15], prev_err_q};
	assign p_full    = 33'(e_s1) * 33'($signed({1'b0, kp}));
	assign d_full    = 34'(diff) * 34'($signed({1'b0, cfg.derivative_gain_per_tick}));
	assign i_full    = 33'(e_s1) * 33'($signed({1'b0, cfg.integral_gain_per_tick}));
	assign at_tol    = dist_s1 < {16'd0, cfg.arrive_tolerance};
	assign vlim      = err_big ? {1'b0, cfg.max_speed[9:1]} : cfg.max_speed;
	assign speed_raw = (dist_s1 < {22'd0, vlim}) ? dist_s1[9:0] : vlim;

	// Stage 2 registers.
	logic signed [31:0] p_s2;
	logic signed [32:0] d_s2;
	logic signed [31:0] kie_s2;
	logic               small_s2, nt_s2, tol_s2;
	logic [9:0]         speed_s2;

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			p_s2     <= p_full[31:0];
			d_s2     <= d_full[32:0];
			kie_s2   <= i_full[31:0];
			small_s2 <= err_small;
			nt_s2    <= nt_s1;
			tol_s2   <= at_tol;
			speed_s2 <= speed_raw;
		end
	end

	// Stage 2 logic: integral accumulate with saturation, arrived mark, P plus D.
	logic signed [39:0] integral_q;
	logic               arrived_q;
	logic signed [40:0] acc;
	logic signed [39:0] acc_sat;
	logic signed [39:0] int_upd;
	logic               arr_next;
	logic signed [33:0] pd_sum;

	assign acc = {integral_q[39], integral_q} + 41'(kie_s2);

	always_comb begin
		if (acc[40] != acc[39])
			acc_sat = acc[40] ? IntMin : IntMax;
		else
			acc_sat = acc[39:0];
	end

	assign int_upd  = small_s2 ? acc_sat : '0;
	assign arr_next = (nt_s2 ? 1'b0 : arrived_q) || tol_s2;
	assign pd_sum   = 34'(p_s2) + 34'(d_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integral_q <= '0;
			arrived_q  <= 1'b1;
		end else if (adv_s2) begin
			integral_q <= arr_next ? '0 : int_upd;
			arrived_q  <= arr_next;
		end
	end

	// Stage 3 registers.
	logic signed [33:0] pd_s3;
	logic signed [39:0] int_s3;
	logic               arr_s3;
	logic [9:0]         speed_s3;

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			pd_s3    <= pd_sum;
			int_s3   <= int_upd;
			arr_s3   <= arr_next;
			speed_s3 <= speed_s2;
		end
	end

	// Stage 3 logic: round Q8.24 to Q4.12, clamp, zero when arrived.
	logic signed [41:0] sum_full;
	logic signed [29:0] rnd;
	logic signed [29:0] lim;
	logic signed [29:0] clamped;

	assign sum_full = 42'(pd_s3) + 42'(int_s3) + RoundHalf;
	assign rnd      = sum_full[41:12];
	assign lim      = $signed({15'd0, cfg.max_steer_angle});

	always_comb begin
		if (rnd > lim)
			clamped = lim;
		else if (rnd < -lim)
			clamped = -lim;
		else
			clamped = rnd;
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (adv_s3) begin
			steer_out <= arr_s3 ? 16'sd0 : clamped[15:0];
			speed_cmd <= arr_s3 ? 10'd0 : speed_s3;
			arrived   <= arr_s3;
		end
	end

endmodule

`default_nettype wire

// File: design/wpss_cfg_regs.sv
// Configuration register file of the waypoint steering and speed controller.
`default_nettype none

module wpss_cfg_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_write,
	input  wire logic [wpss_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire logic [wpss_pkg::CfgDataW-1:0] cfg_data,
	output wpss_pkg::cfg_t                     cfg
);
	import wpss_pkg::*;

	cfg_t cfg_q;

	// Register writes: each register takes the low bits of the write data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_speed                <= RstMaxSpeed;
			cfg_q.max_steer_angle          <= RstMaxSteer;
			cfg_q.arrive_tolerance         <= RstArriveTol;
			cfg_q.gain_near                <= RstGainNear;
			cfg_q.gain_far                 <= RstGainFar;
			cfg_q.gain_switch_distance     <= RstGainSw;
			cfg_q.integral_gain_per_tick   <= RstKi;
			cfg_q.derivative_gain_per_tick <= RstKd;
		end else if (cfg_write) begin
			case (reg_idx_t'(cfg_index))
				REG_MAX_SPEED:   cfg_q.max_speed                <= cfg_data[9:0];
				REG_MAX_STEER:   cfg_q.max_steer_angle          <= cfg_data[14:0];
				REG_ARRIVE_TOL:  cfg_q.arrive_tolerance         <= cfg_data[15:0];
				REG_GAIN_NEAR:   cfg_q.gain_near                <= cfg_data[15:0];
				REG_GAIN_FAR:    cfg_q.gain_far                 <= cfg_data[15:0];
				REG_GAIN_SWITCH: cfg_q.gain_switch_distance     <= cfg_data[19:0];
				REG_KI_PER_TICK: cfg_q.integral_gain_per_tick   <= cfg_data[15:0];
				REG_KD_PER_TICK: cfg_q.derivative_gain_per_tick <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// File: design/wpss_checker.sv
// Port-level checker for the waypoint steering and speed controller, with its bind.
`default_nettype none

module wpss_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_ready,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic signed [15:0] steer_out,
	input wire logic [9:0]         speed_cmd,
	input wire logic               arrived
);

	// An arrived result carries zero commands.
	a_arrived_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && arrived |-> steer_out == 16'sd0 && speed_cmd == 10'd0)
		else $error("arrived result with nonzero command");

	// Input back-pressure only happens when the whole pipeline is full and stalled.
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled while output side can move");

	// A stalled result holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(steer_out) && $stable(speed_cmd)
			&& $stable(arrived))
		else $error("stalled result changed");

endmodule

bind waypoint_pid_steer_speed_unit wpss_checker u_wpss_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.steer_out (steer_out),
	.speed_cmd (speed_cmd),
	.arrived   (arrived)
);

`default_nettype wire
